// File: src/ipt_pkg.sv
// Shared constants and types for the IPv4 prefix trie unit.
`timescale 1ns / 1ps
package ipt_pkg;
  localparam int NodeCountDefault = 4096;
  localparam int KeyBitsDefault   = 32;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdDelete = 2'd1;
  localparam logic [1:0] CmdFind   = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StExists  = 2'd1;
  localparam logic [1:0] StMiss    = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;
endpackage

// File: src/ipv4_prefix_trie_unit.sv
// Top level: command sequencer around the trie node memory.
// Each command walks the trie from the root, reading one node per step; insert then
// allocates and links each new node, from the free stack when it is not empty, and
// delete prunes emptied leaf nodes back up toward the root onto the free stack.
// One command at a time (busy). Reset: a clearing pass over all nodes, busy high.
// No stall: done_o pulses for one cycle.
`timescale 1ns / 1ps
module ipv4_prefix_trie_unit #(
  parameter int NODE_COUNT = ipt_pkg::NodeCountDefault,
  parameter int KEY_BITS   = ipt_pkg::KeyBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [KEY_BITS-1:0] mask_i,
  input  logic [7:0]          entry_value_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [7:0]          match_value_o
);
  localparam int AW = $clog2(NODE_COUNT);
  localparam int DW = AW + AW + AW + 8 + 1; // left, right, parent, value, has
  localparam int BW = $clog2(KEY_BITS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_PRDST = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_MKNEW = 4'd6;
  localparam logic [3:0] S_LINK  = 4'd7;
  localparam logic [3:0] S_UPRD  = 4'd8;
  localparam logic [3:0] S_UP    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_FREAD = 4'd11;

  // node memory: one packed word per node
  logic [DW-1:0] mem [NODE_COUNT];
  logic [AW-1:0] free_mem [NODE_COUNT];
  logic [DW-1:0] rd_q;
  logic [AW-1:0] free_rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata;
  logic          fwe;
  logic [AW-1:0] faddr;
  logic [AW-1:0] fwdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (fwe) free_mem[faddr] <= fwdata;
    free_rd_q <= free_mem[faddr];
  end

  logic [3:0]          st_q, st_d;
  logic [AW:0]         clr_q, clr_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d, mask_q, mask_d;
  logic [7:0]          val_q, val_d;
  logic [BW-1:0]       bit_q, bit_d;     // key bits consumed so far
  logic [AW-1:0]       node_q, node_d, prev_q, prev_d;
  logic [DW-1:0]       word_q, word_d;   // current node word
  logic [AW:0]         next_q, next_d, top_q, top_d;
  logic [AW-1:0]       new_q, new_d;
  logic [1:0]          res_st_q, res_st_d;
  logic                res_f_q, res_f_d;
  logic [7:0]          res_v_q, res_v_d;
  logic                done_q, done_d;

  logic          more;   // current key bit is under the mask
  logic          kbit;
  logic [AW-1:0] wl, wr, wp;
  logic [7:0]    wv;
  logic          wh;
  assign {wl, wr, wp, wv, wh} = word_q;
  assign more = (bit_q < BW'(KEY_BITS)) && mask_q[KEY_BITS-1-bit_q];
  assign kbit = (bit_q < BW'(KEY_BITS)) && key_q[KEY_BITS-1-bit_q];

  always_comb begin
    st_d = st_q; clr_d = clr_q; cmd_d = cmd_q; key_d = key_q; mask_d = mask_q;
    val_d = val_q; bit_d = bit_q; node_d = node_q; prev_d = prev_q;
    word_d = word_q; next_d = next_q; top_d = top_q; new_d = new_q;
    res_st_d = res_st_q; res_f_d = res_f_q; res_v_d = res_v_q; done_d = 1'b0;
    we = 1'b0; waddr = node_q; wdata = word_q; raddr = node_q;
    fwe = 1'b0; faddr = top_q[AW-1:0]; fwdata = node_q;
    case (st_q)
      S_CLR: begin
        we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(NODE_COUNT - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_d = command_i; key_d = key_i; mask_d = mask_i;
          val_d = entry_value_i; bit_d = '0; node_d = '0;
          res_st_d = ipt_pkg::StMiss; res_f_d = 1'b0; res_v_d = '0;
          raddr = '0;
          if (command_i inside {ipt_pkg::CmdInsert, ipt_pkg::CmdDelete, ipt_pkg::CmdFind})
            st_d = S_RD;
          else st_d = S_DONE;
        end
      end
      S_RD: begin
        word_d = rd_q;
        st_d = S_WALK;
      end
      S_WALK: begin
        // word_q holds node_q
        if (cmd_q == ipt_pkg::CmdFind) begin
          if (wh) begin
            res_f_d = 1'b1; res_v_d = wv; res_st_d = ipt_pkg::StOk;
          end
          if (bit_q >= BW'(KEY_BITS) || (kbit ? wr : wl) == '0) st_d = S_DONE;
          else begin
            node_d = kbit ? wr : wl; raddr = node_d;
            bit_d = bit_q + 1'b1; st_d = S_RD;
          end
        end else if (more && (kbit ? wr : wl) != '0) begin
          node_d = kbit ? wr : wl; raddr = node_d;
          bit_d = bit_q + 1'b1; st_d = S_RD;
        end else if (cmd_q == ipt_pkg::CmdInsert) begin
          if (!more) begin
            if (wh) res_st_d = ipt_pkg::StExists;
            else begin
              we = 1'b1; wdata = {wl, wr, wp, val_q, 1'b1};
              res_st_d = ipt_pkg::StOk;
            end
            st_d = S_DONE;
          end else st_d = S_POP;
        end else begin
          // delete
          if (more || node_q == '0) st_d = S_DONE;
          else if (wl != '0 || wr != '0) begin
            if (wh) begin
              we = 1'b1; wdata = {wl, wr, wp, wv, 1'b0};
              res_st_d = ipt_pkg::StOk;
            end
            st_d = S_DONE;
          end else begin
            res_st_d = ipt_pkg::StOk;
            fwe = 1'b1; faddr = top_q[AW-1:0]; fwdata = node_q;
            top_d = top_q + 1'b1;
            prev_d = node_q; node_d = wp; raddr = wp;
            st_d = S_UPRD;
          end
        end
      end
      S_POP: begin
        if (top_q != '0) begin
          faddr = AW'(top_q - 1'b1);
          top_d = top_q - 1'b1;
          st_d = S_PRDST;
        end else if (next_q < (AW+1)'(NODE_COUNT)) begin
          new_d = next_q[AW-1:0]; next_d = next_q + 1'b1;
          st_d = S_MKNEW;
        end else begin
          res_st_d = ipt_pkg::StFull; st_d = S_DONE;
        end
      end
      S_PRDST: begin
        new_d = free_rd_q; st_d = S_MKNEW;
      end
      S_MKNEW: begin
        we = 1'b1; waddr = new_q; wdata = {{AW{1'b0}}, {AW{1'b0}}, node_q, 8'd0, 1'b0};
        st_d = S_LINK;
      end
      S_LINK: begin
        we = 1'b1; waddr = node_q;
        wdata = kbit ? {wl, new_q, wp, wv, wh} : {new_q, wr, wp, wv, wh};
        node_d = new_q; word_d = {{AW{1'b0}}, {AW{1'b0}}, node_q, 8'd0, 1'b0};
        bit_d = bit_q + 1'b1;
        st_d = S_FREAD;
      end
      S_FREAD: begin
        // word_q already holds the fresh node
        if (mask_q[KEY_BITS-1-bit_q] && bit_q < BW'(KEY_BITS)) st_d = S_POP;
        else begin
          we = 1'b1; wdata = {wl, wr, wp, val_q, 1'b1};
          res_st_d = ipt_pkg::StOk; st_d = S_DONE;
        end
      end
      S_UPRD: begin
        word_d = rd_q; st_d = S_UP;
      end
      S_UP: begin
        if (wr == prev_q) wdata = {wl, {AW{1'b0}}, wp, wv, wh};
        else wdata = {{AW{1'b0}}, wr, wp, wv, wh};
        we = 1'b1;
        word_d = wdata;
        if (wdata[DW-1 -: AW] != '0 || wdata[DW-1-AW -: AW] != '0 || wh ||
            node_q == '0) st_d = S_DONE;
        else begin
          fwe = 1'b1; faddr = top_q[AW-1:0]; fwdata = node_q;
          top_d = top_q + 1'b1;
          prev_d = node_q; node_d = wp; raddr = wp;
          st_d = S_UPRD;
        end
      end
      S_DONE: begin
        done_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; next_q <= (AW+1)'(1); top_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; next_q <= next_d; top_q <= top_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; key_q <= key_d; mask_q <= mask_d; val_q <= val_d;
    bit_q <= bit_d; node_q <= node_d; prev_q <= prev_d; word_q <= word_d;
    new_q <= new_d; res_st_q <= res_st_d; res_f_q <= res_f_d; res_v_q <= res_v_d;
  end

  assign busy          = (st_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = res_st_q;
  assign found_o       = res_f_q;
  assign match_value_o = res_v_q;
endmodule
